[hw/rtl/rrf_pkg.sv]
package rrf_pkg;

   // Native panel geometry. Landscape coordinates are rotated onto it.
   localparam int PANEL_NATIVE_WIDTH  = 128;
   localparam int PANEL_NATIVE_HEIGHT = 256;

   localparam int ROW_PITCH   = PANEL_NATIVE_WIDTH / 4;
   localparam int STORE_DEPTH = ROW_PITCH * PANEL_NATIVE_HEIGHT;
   localparam int LAND_COLS   = PANEL_NATIVE_HEIGHT;
   localparam int LAND_ROWS   = PANEL_NATIVE_WIDTH;

   localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int IDX_W   = $clog2(STORE_DEPTH + ROW_PITCH);
   localparam int LX_W    = (LAND_COLS > 1) ? $clog2(LAND_COLS) : 1;
   localparam int LY_W    = $clog2(LAND_ROWS);
   localparam int COORD_W = 12;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_FILL  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] WHITE_BYTE = 8'hFF;

   typedef struct packed {
      logic capture;      // take the request fields
      logic sweep_write;  // write one byte of a whole-store sweep
      logic sweep_white;  // sweep data is white instead of the clear color
      logic pixel_read;   // read the byte holding the current pixel
      logic pixel_write;  // write the merged byte back
      logic pixel_step;   // move to the next pixel of the rectangle
      logic addr_read;    // read the byte of a read command
      logic result_load;  // load the output register
   } rrf_cmd_type;

   typedef struct packed {
      logic rect_empty;   // clipped rectangle on the request has no pixel
      logic sweep_last;   // sweep is at the last byte
      logic pixel_last;   // current pixel is the last of the rectangle
      logic rsp_busy;     // output register holds a stalled beat
   } rrf_status_type;

endpackage

[hw/rtl/rotated_2bpp_rect_fill_engine.sv]
// Rectangle fill engine for a 2-bit-per-pixel framebuffer of 8192 bytes, four pixels
// per byte with the first pixel in bits 7:6. Landscape coordinates on the request
// are rotated onto the native portrait panel before the store is addressed.
// The request channel (req_*) carries one command per beat: clear, fill or read.
// Every request beat yields exactly one response beat on rsp_*; rsp_read_data holds
// the stored byte for a read and zero for every other command.
// Steps per request, from its acceptance to the loading of its response:
//   clear: one write per byte over all 8192 bytes, then the response.
//   fill:  one read and one write of the frame store port per covered pixel, then
//          the response; an empty or fully clipped rectangle goes straight to it.
//   read:  one registered read of the store, then the response.
// Only one request is worked on at a time; req_stall is high while it runs.
// The response waits in an output register, so a stalled receiver does not hold
// the engine back until a second response would have to be loaded.
// After reset the store is swept to white (0xFF), one byte per cycle, over all
// 8192 bytes; req_stall stays high for that whole pass.
module rotated_2bpp_rect_fill_engine
   import rrf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [10:0] req_x_pos,
   input  logic signed [10:0] req_y_pos,
   input  logic [9:0]         req_rect_width,
   input  logic [9:0]         req_rect_height,
   input  logic [1:0]         req_pixel_color,
   input  logic [12:0]        req_read_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_read_data
);

   // The controller sequences sweeps and pixel read-modify-writes; the datapath
   // holds the store, the clipping and the walk counters.
   rrf_cmd_type    cmd;
   rrf_status_type status;

   rrf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   rrf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_pixel_color  (req_pixel_color),
      .req_read_address (req_read_address),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data)
   );

endmodule

[hw/rtl/rrf_ctrl.sv]
module rrf_ctrl
   import rrf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_command,
   output logic           req_stall,
   input  rrf_status_type status,
   output rrf_cmd_type    cmd
);

   localparam logic [2:0] S_INIT    = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_CLEAR   = 3'd2;
   localparam logic [2:0] S_FILL_RD = 3'd3;
   localparam logic [2:0] S_FILL_WR = 3'd4;
   localparam logic [2:0] S_READ_RD = 3'd5;
   localparam logic [2:0] S_FINISH  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep_write = 1'b1;
            cmd.sweep_white = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_command)
                  CMD_CLEAR: state_in = S_CLEAR;
                  CMD_FILL:  state_in = status.rect_empty ? S_FINISH : S_FILL_RD;
                  CMD_READ:  state_in = S_READ_RD;
                  default:   state_in = S_FINISH;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) begin
               state_in = S_FINISH;
            end
         end
         S_FILL_RD: begin
            cmd.pixel_read = 1'b1;
            state_in       = S_FILL_WR;
         end
         S_FILL_WR: begin
            cmd.pixel_write = 1'b1;
            if (status.pixel_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.pixel_step = 1'b1;
               state_in       = S_FILL_RD;
            end
         end
         S_READ_RD: begin
            cmd.addr_read = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/rrf_datapath.sv]
module rrf_datapath
   import rrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_command,
   input  logic signed [10:0]  req_x_pos,
   input  logic signed [10:0]  req_y_pos,
   input  logic [9:0]          req_rect_width,
   input  logic [9:0]          req_rect_height,
   input  logic [1:0]          req_pixel_color,
   input  logic [12:0]         req_read_address,
   input  rrf_cmd_type         cmd,
   output rrf_status_type      status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_read_data
);

   localparam logic signed [COORD_W-1:0] LAND_COLS_S = COORD_W'(LAND_COLS);
   localparam logic signed [COORD_W-1:0] LAND_ROWS_S = COORD_W'(LAND_ROWS);

   // Clipping of the incoming rectangle.
   logic signed [COORD_W-1:0] x_start, y_start, x_end, y_end;
   logic signed [COORD_W-1:0] x_lo, y_lo, x_hi, y_hi;

   always_comb begin
      x_start = COORD_W'(req_x_pos);
      y_start = COORD_W'(req_y_pos);
      x_end   = x_start + $signed({2'b00, req_rect_width});
      y_end   = y_start + $signed({2'b00, req_rect_height});
      x_lo    = (x_start < 0) ? '0 : x_start;
      y_lo    = (y_start < 0) ? '0 : y_start;
      x_hi    = (x_end > LAND_COLS_S) ? LAND_COLS_S : x_end;
      y_hi    = (y_end > LAND_ROWS_S) ? LAND_ROWS_S : y_end;
   end

   logic signed [COORD_W-1:0] x_last_full, y_last_full;
   assign x_last_full = x_hi - COORD_W'(1);
   assign y_last_full = y_hi - COORD_W'(1);

   // Captured command fields and walk registers.
   logic [1:0]        cmd_ff, cmd_in;
   logic [1:0]        color_ff, color_in;
   logic [12:0]       addr_ff, addr_in;
   logic [LX_W-1:0]   x_first_ff, x_first_in, x_last_ff, x_last_in, col_ff, col_in;
   logic [LY_W-1:0]   y_last_ff, y_last_in, row_ff, row_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;

   // Pixel address after rotation: native row = LAND_COLS-1-col, native column = row.
   logic [LX_W-1:0]  native_row;
   logic [IDX_W-1:0] pixel_idx;
   logic             pixel_ok;

   assign native_row = LX_W'(LAND_COLS - 1) - col_ff;
   assign pixel_idx  = IDX_W'(native_row) * IDX_W'(ROW_PITCH) + IDX_W'(row_ff >> 2);
   assign pixel_ok   = pixel_idx < IDX_W'(STORE_DEPTH);

   // Frame store, one write and one registered read per cycle.
   logic [7:0]        store_ff [STORE_DEPTH];
   logic [7:0]        rd_byte_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [7:0]        mem_wd, merged;

   always_comb begin
      unique case (row_ff[1:0])
         2'd0:    merged = {color_ff, rd_byte_ff[5:0]};
         2'd1:    merged = {rd_byte_ff[7:6], color_ff, rd_byte_ff[3:0]};
         2'd2:    merged = {rd_byte_ff[7:4], color_ff, rd_byte_ff[1:0]};
         default: merged = {rd_byte_ff[7:2], color_ff};
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = sweep_ff;
      mem_wd = cmd.sweep_white ? WHITE_BYTE : {4{color_ff}};
      if (cmd.sweep_write) begin
         mem_we = 1'b1;
      end else if (cmd.pixel_write && pixel_ok) begin
         mem_we = 1'b1;
         mem_wa = ADDR_W'(pixel_idx);
         mem_wd = merged;
      end
      mem_re = cmd.pixel_read || cmd.addr_read;
      mem_ra = cmd.addr_read ? ADDR_W'(addr_ff) : ADDR_W'(pixel_idx);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_byte_ff <= store_ff[mem_ra];
      end
   end

   always_comb begin
      cmd_in     = cmd_ff;
      color_in   = color_ff;
      addr_in    = addr_ff;
      x_first_in = x_first_ff;
      x_last_in  = x_last_ff;
      y_last_in  = y_last_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      sweep_in   = sweep_ff;
      if (cmd.capture) begin
         cmd_in     = req_command;
         color_in   = req_pixel_color;
         addr_in    = req_read_address;
         x_first_in = LX_W'(x_lo);
         x_last_in  = LX_W'(x_last_full);
         y_last_in  = LY_W'(y_last_full);
         col_in     = LX_W'(x_lo);
         row_in     = LY_W'(y_lo);
         sweep_in   = '0;
      end
      if (cmd.sweep_write) begin
         sweep_in = sweep_ff + ADDR_W'(1);
      end
      if (cmd.pixel_step) begin
         if (col_ff == x_last_ff) begin
            col_in = x_first_ff;
            row_in = row_ff + LY_W'(1);
         end else begin
            col_in = col_ff + LX_W'(1);
         end
      end
   end

   // Output register: a result waits here while the block goes back to idle.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ((cmd_ff == CMD_READ) && (32'(addr_ff) < STORE_DEPTH))
                        ? rd_byte_ff : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      color_ff    <= color_in;
      addr_ff     <= addr_in;
      x_first_ff  <= x_first_in;
      x_last_ff   <= x_last_in;
      y_last_ff   <= y_last_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.rect_empty = (x_hi <= x_lo) || (y_hi <= y_lo);
   assign status.sweep_last = (sweep_ff == ADDR_W'(STORE_DEPTH - 1));
   assign status.pixel_last = (col_ff == x_last_ff) && (row_ff == y_last_ff);
   assign status.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule
